@@ sv/lbom_pkg.sv @@
`default_nettype none

package lbom_pkg;

  localparam int unsigned CoordW  = 21;
  localparam int unsigned RadiusW = 20;
  localparam int unsigned FracW   = 19;
  localparam int unsigned PackW   = 3 * CoordW;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = DiffW + CoordW;
  localparam int unsigned SumW    = ProdW + 2;

  localparam int unsigned MaskW     = 32;
  localparam int unsigned MaxLights = 32;
  localparam int unsigned MaskLimit = (MaxLights < MaskW) ? MaxLights : MaskW;
  localparam int unsigned CountW    = $clog2(MaskLimit + 1);
  localparam int unsigned BitIdxW   = $clog2(MaskW);

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_BOX_MIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MAX   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_ROWX = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_ROWY = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_ROWZ = 3'd5;

  localparam logic [PackW-1:0] RowXReset = PackW'(1) << FracW;
  localparam logic [PackW-1:0] RowYReset = PackW'(1) << (FracW + CoordW);
  localparam logic [PackW-1:0] RowZReset = PackW'(1) << (FracW + 2 * CoordW);

  typedef struct packed {
    logic [PackW-1:0]        box_min;
    logic [PackW-1:0]        box_max;
    logic [PackW-1:0]        origin;
    logic [2:0][PackW-1:0]   axis_row;
  } lbom_cfg_t;

  typedef struct packed {
    logic hit;
    logic last;
  } lbom_hit_t;

  function automatic logic signed [CoordW-1:0] get_field(input logic [PackW-1:0] p,
                                                         input int unsigned k);
    return p[CoordW*k +: CoordW];
  endfunction

endpackage

`default_nettype wire

@@ sv/light_box_overlap_mask_unit.sv @@
// Throughput: one light per cycle unless stalled, through a 4-stage cull pipeline
// (origin subtract, nine multipliers, axis sums, bound compares) followed by the
// mask register; a last light's result then goes to the output register.
// Reset: clears pipeline valids, running mask, light count and overflow flag;
// box and origin registers go to zero, axis rows to identity.
`default_nettype none

module light_box_overlap_mask_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic        [lbom_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic        [lbom_pkg::PackW-1:0]     cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_x_i,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_y_i,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_z_i,
  input  wire logic        [lbom_pkg::RadiusW-1:0]   light_radius_i,
  input  wire logic                                  last_light_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic             [lbom_pkg::MaskW-1:0]     light_mask_o,
  output logic                                       any_light_o,
  output logic                                       too_many_lights_o
);

  lbom_pkg::lbom_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_min     <= '0;
      cfg_q.box_max     <= '0;
      cfg_q.origin      <= '0;
      cfg_q.axis_row[0] <= lbom_pkg::RowXReset;
      cfg_q.axis_row[1] <= lbom_pkg::RowYReset;
      cfg_q.axis_row[2] <= lbom_pkg::RowZReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lbom_pkg::CFG_BOX_MIN:   cfg_q.box_min     <= cfg_data_i;
        lbom_pkg::CFG_BOX_MAX:   cfg_q.box_max     <= cfg_data_i;
        lbom_pkg::CFG_ORIGIN:    cfg_q.origin      <= cfg_data_i;
        lbom_pkg::CFG_AXIS_ROWX: cfg_q.axis_row[0] <= cfg_data_i;
        lbom_pkg::CFG_AXIS_ROWY: cfg_q.axis_row[1] <= cfg_data_i;
        lbom_pkg::CFG_AXIS_ROWZ: cfg_q.axis_row[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                 hit_valid;
  lbom_pkg::lbom_hit_t  hit;
  logic                 hit_ready;
  logic                 out_free;

  lbom_cull u_cull (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .light_x_i,
    .light_y_i,
    .light_z_i,
    .light_radius_i,
    .last_light_i   (last_light_i),
    .hit_valid_o    (hit_valid),
    .hit_o          (hit),
    .hit_ready_i    (hit_ready)
  );

  logic [lbom_pkg::MaskW-1:0]  mask_q, mask_d;
  logic [lbom_pkg::CountW-1:0] count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        take;

  assign out_free  = !out_valid_o || !out_stall_i;
  assign hit_ready = !hit.last || out_free;
  assign take      = hit_valid && hit_ready;

  always_comb begin
    mask_d  = mask_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (count_q < lbom_pkg::CountW'(lbom_pkg::MaskLimit)) begin
      if (hit.hit) begin
        mask_d[count_q[lbom_pkg::BitIdxW-1:0]] = 1'b1;
      end
      count_d = count_q + 1'b1;
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (take) begin
        if (hit.last) begin
          mask_q  <= '0;
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          mask_q  <= mask_d;
          count_q <= count_d;
          ovf_q   <= ovf_d;
        end
      end
      if (out_free) begin
        out_valid_o <= take && hit.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hit.last) begin
      light_mask_o      <= mask_d;
      any_light_o       <= |mask_d;
      too_many_lights_o <= ovf_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lbom_pkg::CountW'(lbom_pkg::MaskLimit))
    else $error("light count beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == lbom_pkg::CountW'(lbom_pkg::MaskLimit)))
    else $error("overflow flagged before count saturated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((64'(mask_q) >> count_q) == 64'd0))
    else $error("mask bit set at or above light count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && hit.last) |=> (out_valid_o && (mask_q == '0) && (count_q == '0)))
    else $error("list end did not emit result and restart");

endmodule

`default_nettype wire

@@ sv/lbom_cull.sv @@
`default_nettype none

module lbom_cull (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lbom_pkg::lbom_cfg_t                   cfg_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_x_i,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_y_i,
  input  wire logic signed [lbom_pkg::CoordW-1:0]    light_z_i,
  input  wire logic        [lbom_pkg::RadiusW-1:0]   light_radius_i,
  input  wire logic                                  last_light_i,
  output logic                                       hit_valid_o,
  output lbom_pkg::lbom_hit_t                        hit_o,
  input  wire logic                                  hit_ready_i
);

  // stage a: origin removed
  logic                                    a_v_q;
  logic signed [lbom_pkg::DiffW-1:0]       a_d_q [3];
  logic        [lbom_pkg::RadiusW-1:0]     a_r_q;
  logic                                    a_last_q;
  // stage b: products and widened bounds
  logic                                    b_v_q;
  logic signed [lbom_pkg::ProdW-1:0]       b_p_q [3][3];
  logic signed [lbom_pkg::DiffW-1:0]       b_hi_q [3];
  logic signed [lbom_pkg::DiffW-1:0]       b_lo_q [3];
  logic                                    b_last_q;
  // stage c: rotated coordinates
  logic                                    c_v_q;
  logic signed [lbom_pkg::SumW-1:0]        c_t_q [3];
  logic signed [lbom_pkg::DiffW-1:0]       c_hi_q [3];
  logic signed [lbom_pkg::DiffW-1:0]       c_lo_q [3];
  logic                                    c_last_q;
  // stage d: overlap result
  logic                                    d_v_q;
  logic                                    d_hit_q;
  logic                                    d_last_q;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !d_v_q || hit_ready_i;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;
  assign in_stall_o = !rdy_a;

  logic signed [lbom_pkg::CoordW-1:0]  light [3];
  logic signed [lbom_pkg::DiffW-1:0]   a_d_d [3];
  logic signed [lbom_pkg::DiffW-1:0]   r_ext;
  logic signed [lbom_pkg::ProdW-1:0]   b_p_d [3][3];
  logic signed [lbom_pkg::DiffW-1:0]   b_hi_d [3];
  logic signed [lbom_pkg::DiffW-1:0]   b_lo_d [3];
  logic signed [lbom_pkg::SumW-1:0]    c_t_d [3];
  logic signed [lbom_pkg::SumW-1:0]    hi_s [3];
  logic signed [lbom_pkg::SumW-1:0]    lo_s [3];
  logic                                d_hit_d;

  assign light[0] = light_x_i;
  assign light[1] = light_y_i;
  assign light[2] = light_z_i;
  assign r_ext    = $signed({2'b00, a_r_q});

  always_comb begin
    d_hit_d = 1'b1;
    for (int unsigned a = 0; a < 3; a++) begin
      a_d_d[a] = lbom_pkg::DiffW'(light[a])
               - lbom_pkg::DiffW'(lbom_pkg::get_field(cfg_i.origin, a));
      b_hi_d[a] = lbom_pkg::DiffW'(lbom_pkg::get_field(cfg_i.box_max, a)) + r_ext;
      b_lo_d[a] = lbom_pkg::DiffW'(lbom_pkg::get_field(cfg_i.box_min, a)) - r_ext;
      for (int unsigned k = 0; k < 3; k++) begin
        b_p_d[a][k] = lbom_pkg::ProdW'(a_d_q[k])
                    * lbom_pkg::ProdW'(lbom_pkg::get_field(cfg_i.axis_row[a], k));
      end
      c_t_d[a] = lbom_pkg::SumW'(b_p_q[a][0]) + lbom_pkg::SumW'(b_p_q[a][1])
               + lbom_pkg::SumW'(b_p_q[a][2]);
      hi_s[a] = lbom_pkg::SumW'($signed({c_hi_q[a], {lbom_pkg::FracW{1'b0}}}));
      lo_s[a] = lbom_pkg::SumW'($signed({c_lo_q[a], {lbom_pkg::FracW{1'b0}}}));
      if ((c_t_q[a] > hi_s[a]) || (c_t_q[a] < lo_s[a])) begin
        d_hit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= in_valid_i;
      if (rdy_b) b_v_q <= a_v_q;
      if (rdy_c) c_v_q <= b_v_q;
      if (rdy_d) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_d_q    <= a_d_d;
      a_r_q    <= light_radius_i;
      a_last_q <= last_light_i;
    end
    if (rdy_b && a_v_q) begin
      b_p_q    <= b_p_d;
      b_hi_q   <= b_hi_d;
      b_lo_q   <= b_lo_d;
      b_last_q <= a_last_q;
    end
    if (rdy_c && b_v_q) begin
      c_t_q    <= c_t_d;
      c_hi_q   <= b_hi_q;
      c_lo_q   <= b_lo_q;
      c_last_q <= b_last_q;
    end
    if (rdy_d && c_v_q) begin
      d_hit_q  <= d_hit_d;
      d_last_q <= c_last_q;
    end
  end

  assign hit_valid_o = d_v_q;
  assign hit_o.hit   = d_hit_q;
  assign hit_o.last  = d_last_q;

endmodule

`default_nettype wire

@@ test/light_box_overlap_mask_unit_test.sv @@
`default_nettype none

module light_box_overlap_mask_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbom_pkg::*;

  localparam int ResetCycles   = 8;
  localparam int SettleCycles  = 10;
  localparam int RandomLights  = 650;
  localparam int PhaseCount    = 9;
  localparam int PressurePhase = 6;
  localparam int HoldCycles    = 80;
  localparam int TimeoutCycles = 400_000;
  localparam int TableRows     = 10;
  localparam longint FracScale = 64'sd1 << FracW;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  localparam logic [CoordW-1:0] FieldMin     = 21'h100000;
  localparam logic [CoordW-1:0] FieldMax     = 21'h0FFFFF;
  localparam logic [CoordW-1:0] AxisOne      = 21'h080000;
  localparam logic [CoordW-1:0] AxisMinusOne = 21'h180000;

  typedef enum int {
    SetupUseful,
    SetupExtreme,
    SetupNoise
  } setup_kind_e;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadiusW-1:0]       radius;
    logic                     last;
  } light_t;

  typedef struct {
    logic [MaskW-1:0] mask;
    logic             any;
    logic             overflow;
  } mask_result_t;

  typedef struct {
    logic         known;
    mask_result_t want;
  } table_note_t;

  typedef struct {
    light_t      l;
    table_note_t note;
  } table_row_t;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     cfg_valid_i       = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i       = CFG_BOX_MIN;
  logic [PackW-1:0]         cfg_data_i        = '0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] light_x_i         = '0;
  logic signed [CoordW-1:0] light_y_i         = '0;
  logic signed [CoordW-1:0] light_z_i         = '0;
  logic [RadiusW-1:0]       light_radius_i    = '0;
  logic                     last_light_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i       = 1'b0;
  logic [MaskW-1:0]         light_mask_o;
  logic                     any_light_o;
  logic                     too_many_lights_o;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 78;
  int unsigned hold_requests = 0;
  int unsigned errors        = 0;

  lbom_cfg_t        shadow_cfg;
  logic [MaskW-1:0] running_mask;
  int unsigned      lights_in_list;
  logic             overflow_seen;
  mask_result_t     expected_masks[$];
  table_note_t      table_notes[$];
  light_t           arrived;
  mask_result_t     want_now;

  light_box_overlap_mask_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .light_x_i        (light_x_i),
    .light_y_i        (light_y_i),
    .light_z_i        (light_z_i),
    .light_radius_i   (light_radius_i),
    .last_light_i     (last_light_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .light_mask_o     (light_mask_o),
    .any_light_o      (any_light_o),
    .too_many_lights_o(too_many_lights_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint packed_coord(input logic [PackW-1:0] p, input int k);
    longint v;
    v = $signed(p[CoordW*k +: CoordW]);
    return v;
  endfunction

  function automatic table_row_t mk_row(input int x, input int y, input int z, input int r,
                                        input logic last, input logic known,
                                        input logic [MaskW-1:0] mask, input logic any,
                                        input logic ovf);
    table_row_t row;
    row.l.x             = CoordW'(x);
    row.l.y             = CoordW'(y);
    row.l.z             = CoordW'(z);
    row.l.radius        = RadiusW'(r);
    row.l.last          = last;
    row.note.known      = known;
    row.note.want.mask  = mask;
    row.note.want.any   = any;
    row.note.want.overflow = ovf;
    return row;
  endfunction

  // cull one light against the shadow setup, queue the mask on a last light
  task automatic cull_light(input light_t l);
    longint       offs[3];
    longint       rot;
    longint       reach;
    longint       hi;
    longint       lo;
    logic         hit;
    mask_result_t res;
    table_note_t  note;
    offs[0] = longint'(l.x) - packed_coord(shadow_cfg.origin, 0);
    offs[1] = longint'(l.y) - packed_coord(shadow_cfg.origin, 1);
    offs[2] = longint'(l.z) - packed_coord(shadow_cfg.origin, 2);
    reach   = longint'(l.radius) * FracScale;
    hit     = 1'b1;
    for (int a = 0; a < 3; a++) begin
      rot = 0;
      for (int k = 0; k < 3; k++) begin
        rot += offs[k] * packed_coord(shadow_cfg.axis_row[a], k);
      end
      hi = packed_coord(shadow_cfg.box_max, a) * FracScale;
      lo = packed_coord(shadow_cfg.box_min, a) * FracScale;
      if (rot - hi > reach || lo - rot > reach) hit = 1'b0;
    end
    if (lights_in_list < MaskLimit) begin
      if (hit) running_mask[lights_in_list] = 1'b1;
      lights_in_list++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (table_notes.size() != 0) note = table_notes.pop_front();
    else note.known = 1'b0;
    if (l.last) begin
      res.mask     = running_mask;
      res.any      = (running_mask != '0);
      res.overflow = overflow_seen;
      if (note.known) expected_masks.push_back(note.want);
      else expected_masks.push_back(res);
      running_mask   = '0;
      lights_in_list = 0;
      overflow_seen  = 1'b0;
    end
  endtask

  initial begin
    shadow_cfg.box_min     = '0;
    shadow_cfg.box_max     = '0;
    shadow_cfg.origin      = '0;
    shadow_cfg.axis_row[0] = RowXReset;
    shadow_cfg.axis_row[1] = RowYReset;
    shadow_cfg.axis_row[2] = RowZReset;
    running_mask           = '0;
    lights_in_list         = 0;
    overflow_seen          = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BOX_MIN:   shadow_cfg.box_min     = cfg_data_i;
          CFG_BOX_MAX:   shadow_cfg.box_max     = cfg_data_i;
          CFG_ORIGIN:    shadow_cfg.origin      = cfg_data_i;
          CFG_AXIS_ROWX: shadow_cfg.axis_row[0] = cfg_data_i;
          CFG_AXIS_ROWY: shadow_cfg.axis_row[1] = cfg_data_i;
          CFG_AXIS_ROWZ: shadow_cfg.axis_row[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        arrived.x      = light_x_i;
        arrived.y      = light_y_i;
        arrived.z      = light_z_i;
        arrived.radius = light_radius_i;
        arrived.last   = last_light_i;
        cull_light(arrived);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_masks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, mask %h", $time, light_mask_o);
        end else begin
          want_now = expected_masks.pop_front();
          if (light_mask_o !== want_now.mask) begin
            errors++;
            $display("%0t: light_mask expected %h got %h", $time, want_now.mask,
                     light_mask_o);
          end
          if (any_light_o !== want_now.any) begin
            errors++;
            $display("%0t: any_light expected %b got %b", $time, want_now.any, any_light_o);
          end
          if (too_many_lights_o !== want_now.overflow) begin
            errors++;
            $display("%0t: too_many_lights expected %b got %b", $time, want_now.overflow,
                     too_many_lights_o);
          end
        end
      end
    end
  end

  // receiver side, with the long hold-off counted here
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_light(input light_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    light_x_i      <= l.x;
    light_y_i      <= l.y;
    light_z_i      <= l.z;
    light_radius_i <= l.radius;
    last_light_i   <= l.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_masks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    table_row_t         light_table[TableRows];
    setup_kind_e        phase_kind[PhaseCount];
    logic [CfgIdxW-1:0] reg_order[8];
    logic [PackW-1:0]   reg_vals[8];
    lbom_cfg_t          setup;
    light_t             l;
    int                 mins[3];
    int                 maxs[3];
    int                 org[3];
    int                 center;
    int                 half;
    int                 spin;
    int                 len;
    int                 sent;
    logic [CoordW-1:0]  pick[4];

    // reset setup: zero-size box at origin, identity axes
    light_table[0] = mk_row(0, 0, 0, 0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[1] = mk_row(16, 0, 0, 0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[2] = mk_row(16, 0, 0, 16, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[3] = mk_row(0, -17, 0, 16, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[4] = mk_row(0, 0, 1048575, 1048575, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[5] = mk_row(-1048576, 0, 0, 1048575, 1'b1, 1'b1, 32'h15, 1'b1, 1'b0);
    light_table[6] = mk_row(100, 0, 0, 0, 1'b1, 1'b1, '0, 1'b0, 1'b0);
    light_table[7] = mk_row(-1048575, -1048575, -1048575, 1048575, 1'b1, 1'b1, 32'h1,
                            1'b1, 1'b0);
    light_table[8] = mk_row(5, 5, 5, 3, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    light_table[9] = mk_row(-3, 2, -1, 7, 1'b1, 1'b0, '0, 1'b0, 1'b0);

    phase_kind = '{SetupExtreme, SetupUseful, SetupNoise, SetupUseful, SetupExtreme,
                   SetupNoise, SetupUseful, SetupUseful, SetupNoise};
    reg_order  = '{CFG_BOX_MIN, CFG_BOX_MAX, CfgSpareA, CFG_ORIGIN, CFG_AXIS_ROWX,
                   CFG_AXIS_ROWY, CfgSpareB, CFG_AXIS_ROWZ};
    pick       = '{FieldMin, FieldMax, '0, AxisOne};

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < TableRows; i++) begin
      table_notes.push_back(light_table[i].note);
      send_light(light_table[i].l);
    end
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 12;
      end
      if (p == PressurePhase) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase_kind[p])
        SetupUseful: begin
          for (int a = 0; a < 3; a++) begin
            center  = $urandom_range(8192) - 4096;
            half    = $urandom_range(4096);
            mins[a] = center - half;
            maxs[a] = center + half;
            if ($urandom_range(7) == 0) begin
              mins[a] = center + half;
              maxs[a] = center - half;
            end
            org[a] = $urandom_range(131072) - 65536;
          end
          setup.box_min = {CoordW'(mins[2]), CoordW'(mins[1]), CoordW'(mins[0])};
          setup.box_max = {CoordW'(maxs[2]), CoordW'(maxs[1]), CoordW'(maxs[0])};
          setup.origin  = {CoordW'(org[2]), CoordW'(org[1]), CoordW'(org[0])};
          spin = $urandom_range(2);
          for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
              if ($urandom_range(1) == 0)
                setup.axis_row[a][CoordW*k +: CoordW] =
                    (k != (a + spin) % 3) ? '0 : ($urandom_range(1) ? AxisOne : AxisMinusOne);
              else
                setup.axis_row[a][CoordW*k +: CoordW] = CoordW'(
                    int'($urandom_range(1 << (FracW + 1))) - (1 << FracW));
            end
          end
        end
        SetupExtreme: begin
          setup.box_min = (p == 0) ? {3{FieldMin}} : {3{FieldMax}};
          setup.box_max = (p == 0) ? {3{FieldMax}} : {3{FieldMin}};
          setup.origin  = (p == 0) ? {3{FieldMax}} : {3{FieldMin}};
          for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
              setup.axis_row[a][CoordW*k +: CoordW] = pick[$urandom_range(3)];
            end
          end
        end
        default: begin
          setup.box_min = PackW'({$urandom, $urandom});
          setup.box_max = PackW'({$urandom, $urandom});
          setup.origin  = PackW'({$urandom, $urandom});
          for (int a = 0; a < 3; a++) setup.axis_row[a] = PackW'({$urandom, $urandom});
        end
      endcase

      reg_vals = '{setup.box_min, setup.box_max, PackW'({$urandom, $urandom}),
                   setup.origin, setup.axis_row[0], setup.axis_row[1],
                   PackW'({$urandom, $urandom}), setup.axis_row[2]};
      for (int i = 0; i < 8; i++) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= reg_order[i];
        cfg_data_i  <= reg_vals[i];
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        @(negedge clk_i);
      end
      cfg_valid_i <= 1'b0;

      if (p == PressurePhase) hold_requests++;

      sent = 0;
      while (sent < RandomLights / PhaseCount) begin
        spin = $urandom_range(9);
        if (p == PressurePhase) len = 1;
        else if (spin < 6) len = $urandom_range(8, 1);
        else if (spin < 8) len = $urandom_range(31, 9);
        else if (spin == 8) len = MaskLimit;
        else len = $urandom_range(MaskLimit + 8, MaskLimit + 1);
        for (int i = 0; i < len; i++) begin
          if (phase_kind[p] == SetupUseful && $urandom_range(7) != 0) begin
            l.x = CoordW'(packed_coord(setup.origin, 0) + $urandom_range(16384) - 8192);
            l.y = CoordW'(packed_coord(setup.origin, 1) + $urandom_range(16384) - 8192);
            l.z = CoordW'(packed_coord(setup.origin, 2) + $urandom_range(16384) - 8192);
          end else begin
            l.x = ($urandom_range(3) == 0) ? pick[$urandom_range(1)] : CoordW'($urandom);
            l.y = ($urandom_range(3) == 0) ? pick[$urandom_range(1)] : CoordW'($urandom);
            l.z = ($urandom_range(3) == 0) ? pick[$urandom_range(1)] : CoordW'($urandom);
          end
          l.radius = ($urandom_range(7) == 0) ? RadiusW'($urandom) : RadiusW'($urandom_range(4096));
          // now and then a list runs on into the next one
          l.last   = (i == len - 1) && ($urandom_range(15) != 0);
          send_light(l);
        end
        sent += len;
      end
      settle();
    end

    if (errors == 0 && expected_masks.size() == 0) begin
      $display("light_box_overlap_mask_unit_test: done, clean");
    end else begin
      $display("light_box_overlap_mask_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("light_box_overlap_mask_unit_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
